// ===== src/cbpg_pkg.sv =====
// Shared constants for the cubic Bezier point generator.
`default_nettype none
package cbpg_pkg;
    localparam int T_BITS   = 16;
    localparam int W_BITS   = 3 * T_BITS;          // weight fraction bits
    localparam int CNT_BITS = 6;
    localparam int T_W      = T_BITS + 1;          // t holds 1.0 exactly
endpackage
`default_nettype wire

// ===== src/cbpg_seq.sv =====
// Point sequencer: walks i = 0..n for each accepted item.
`default_nettype none
module cbpg_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cbpg_pkg::CNT_BITS-1:0] n_in,
    input  wire logic                          hold,
    input  wire logic                          adv,
    output logic                               s_valid,
    output logic [cbpg_pkg::CNT_BITS-1:0]      s_idx,
    output logic [cbpg_pkg::CNT_BITS-1:0]      s_n,
    output logic                               s_last
);
    import cbpg_pkg::*;
    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] n_reg, n_next;

    // Take a new item only once the previous one has cleared the head stages
    assign in_ready = !busy_reg && !hold;
    assign s_valid  = busy_reg;
    assign s_idx    = idx_reg;
    assign s_n      = n_reg;
    assign s_last   = (idx_reg == n_reg);

    // Load on accept, advance on issue, drop busy after the last point
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        n_next    = n_reg;
        if (in_ready && in_valid)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            n_next    = n_in;
        end
        else if (busy_reg && adv)
        begin
            if (s_last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            n_reg    <= n_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/cbpg_pipe.sv =====
// Blend pipeline: t, weights, products, sum, round.
`default_nettype none
module cbpg_pipe #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          i_valid,
    input  wire logic [cbpg_pkg::CNT_BITS-1:0] i_idx,
    input  wire logic [cbpg_pkg::CNT_BITS-1:0] i_n,
    input  wire logic                          i_last,
    input  wire logic signed [COORD_WIDTH-1:0] cx [4],
    input  wire logic signed [COORD_WIDTH-1:0] cy [4],
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_x,
    output logic signed [COORD_WIDTH-1:0]      o_y,
    output logic [cbpg_pkg::CNT_BITS-1:0]      o_idx,
    output logic                               o_last,
    output logic                               o_head_busy
);
    import cbpg_pkg::*;
    localparam int NS       = 6;
    localparam int PW       = COORD_WIDTH + W_BITS + 3;  // signed product width
    localparam int AW       = PW + 2;
    localparam int WW       = W_BITS + 2;                // weight width
    localparam int SPLIT    = WW / 2;                    // low weight part width
    localparam int LW       = COORD_WIDTH + WW - SPLIT + 1;  // partial product width
    localparam int SW       = LW + 2;
    localparam int MV       = CNT_BITS + T_BITS;         // i*2^T_BITS + n/2
    localparam int RS       = MV + CNT_BITS;             // reciprocal scale
    localparam int RW       = RS + 1;
    localparam int MW       = MV + RW;
    localparam int CX_STAGE = 3;                         // stages ahead of the products
    localparam longint R1   = (64'sd1 <<< RS) - 1;

    // Reciprocals ceil(2^RS / n); exact quotient for every i and n
    localparam logic [RW-1:0] RECIP [1 << CNT_BITS] = '{
        RW'(0),         RW'(R1/1+1),    RW'(R1/2+1),    RW'(R1/3+1),
        RW'(R1/4+1),    RW'(R1/5+1),    RW'(R1/6+1),    RW'(R1/7+1),
        RW'(R1/8+1),    RW'(R1/9+1),    RW'(R1/10+1),   RW'(R1/11+1),
        RW'(R1/12+1),   RW'(R1/13+1),   RW'(R1/14+1),   RW'(R1/15+1),
        RW'(R1/16+1),   RW'(R1/17+1),   RW'(R1/18+1),   RW'(R1/19+1),
        RW'(R1/20+1),   RW'(R1/21+1),   RW'(R1/22+1),   RW'(R1/23+1),
        RW'(R1/24+1),   RW'(R1/25+1),   RW'(R1/26+1),   RW'(R1/27+1),
        RW'(R1/28+1),   RW'(R1/29+1),   RW'(R1/30+1),   RW'(R1/31+1),
        RW'(R1/32+1),   RW'(R1/33+1),   RW'(R1/34+1),   RW'(R1/35+1),
        RW'(R1/36+1),   RW'(R1/37+1),   RW'(R1/38+1),   RW'(R1/39+1),
        RW'(R1/40+1),   RW'(R1/41+1),   RW'(R1/42+1),   RW'(R1/43+1),
        RW'(R1/44+1),   RW'(R1/45+1),   RW'(R1/46+1),   RW'(R1/47+1),
        RW'(R1/48+1),   RW'(R1/49+1),   RW'(R1/50+1),   RW'(R1/51+1),
        RW'(R1/52+1),   RW'(R1/53+1),   RW'(R1/54+1),   RW'(R1/55+1),
        RW'(R1/56+1),   RW'(R1/57+1),   RW'(R1/58+1),   RW'(R1/59+1),
        RW'(R1/60+1),   RW'(R1/61+1),   RW'(R1/62+1),   RW'(R1/63+1)
    };

    logic [NS-1:0]       v_reg;
    logic [CNT_BITS-1:0] idx_reg [NS];
    logic                last_reg [NS];

    // Stage 1: scaled index times reciprocal of n
    logic [MW-1:0] m1_reg;
    // Stage 2: t, 1-t and their products
    logic [T_W-1:0]   t2_reg, u2_reg;
    logic [2*T_W-1:0] tt2_reg, uu2_reg, ut2_reg;
    // Stage 3: weights
    logic [WW-1:0] w3_reg [4];
    // Stage 4: products on the low and high weight parts
    logic signed [LW-1:0] plx4_reg [4], phx4_reg [4], ply4_reg [4], phy4_reg [4];
    // Stage 5: sums of the partial products
    logic signed [SW-1:0] lx5_reg, hx5_reg, ly5_reg, hy5_reg;
    // Stage 6: round
    logic signed [COORD_WIDTH-1:0] x6_reg, y6_reg;

    logic [MV-1:0]        m_val;
    logic [T_W-1:0]       t_s, u_s;
    logic signed [AW-1:0] ax, ay;

    // t = floor((i*2^(T_BITS+1) + n) / 2n) = floor((i*2^T_BITS + n/2) / n)
    assign m_val = {i_idx, {T_BITS{1'b0}}} + MV'(i_n >> 1);
    assign t_s   = m1_reg[RS +: T_W];
    assign u_s   = T_W'(1 << T_BITS) - t_s;
    assign ax = (AW'(hx5_reg) <<< SPLIT) + AW'(lx5_reg) + (AW'(1) <<< (W_BITS - 1));
    assign ay = (AW'(hy5_reg) <<< SPLIT) + AW'(ly5_reg) + (AW'(1) <<< (W_BITS - 1));

    // Advance valid bits and tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], i_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg[0]  <= i_idx;
            last_reg[0] <= i_last;
            for (int k = 1; k < NS; k++)
            begin
                idx_reg[k]  <= idx_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
            m1_reg  <= MW'(m_val) * MW'(RECIP[i_n]);
            t2_reg  <= t_s;
            u2_reg  <= u_s;
            tt2_reg <= (2*T_W)'(t_s) * (2*T_W)'(t_s);
            uu2_reg <= (2*T_W)'(u_s) * (2*T_W)'(u_s);
            ut2_reg <= (2*T_W)'(u_s) * (2*T_W)'(t_s);
            w3_reg[0] <= WW'(uu2_reg) * WW'(u2_reg);
            w3_reg[1] <= WW'(3) * (WW'(ut2_reg) * WW'(u2_reg));
            w3_reg[2] <= WW'(3) * (WW'(ut2_reg) * WW'(t2_reg));
            w3_reg[3] <= WW'(tt2_reg) * WW'(t2_reg);
            for (int k = 0; k < 4; k++)
            begin
                plx4_reg[k] <= LW'(cx[k]) * LW'($signed({1'b0, w3_reg[k][SPLIT-1:0]}));
                phx4_reg[k] <= LW'(cx[k]) * LW'($signed({1'b0, w3_reg[k][WW-1:SPLIT]}));
                ply4_reg[k] <= LW'(cy[k]) * LW'($signed({1'b0, w3_reg[k][SPLIT-1:0]}));
                phy4_reg[k] <= LW'(cy[k]) * LW'($signed({1'b0, w3_reg[k][WW-1:SPLIT]}));
            end
            lx5_reg <= (SW'(plx4_reg[0]) + SW'(plx4_reg[1]))
                     + (SW'(plx4_reg[2]) + SW'(plx4_reg[3]));
            hx5_reg <= (SW'(phx4_reg[0]) + SW'(phx4_reg[1]))
                     + (SW'(phx4_reg[2]) + SW'(phx4_reg[3]));
            ly5_reg <= (SW'(ply4_reg[0]) + SW'(ply4_reg[1]))
                     + (SW'(ply4_reg[2]) + SW'(ply4_reg[3]));
            hy5_reg <= (SW'(phy4_reg[0]) + SW'(phy4_reg[1]))
                     + (SW'(phy4_reg[2]) + SW'(phy4_reg[3]));
            x6_reg <= COORD_WIDTH'(ax >>> W_BITS);
            y6_reg <= COORD_WIDTH'(ay >>> W_BITS);
        end
    end

    assign o_valid     = v_reg[NS-1];
    assign o_x         = x6_reg;
    assign o_y         = y6_reg;
    assign o_idx       = idx_reg[NS-1];
    assign o_last      = last_reg[NS-1];
    // Points that have not yet read the control points
    assign o_head_busy = |v_reg[CX_STAGE-1:0];
endmodule
`default_nettype wire

// ===== src/cubic_bezier_point_generator.sv =====
// Top level: cubic Bezier point generator.
// Throughput: one point per cycle while out_ready does not stall the pipe. An item
// is accepted, its segment_count+1 points are issued in turn, and the stages ahead
// of the control point registers drain before the next item is accepted.
// Reset: asynchronous, active low; clears sequencer and valid bits.
`default_nettype none
module cubic_bezier_point_generator #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] p0_x,
    input  wire logic signed [COORD_WIDTH-1:0] p0_y,
    input  wire logic signed [COORD_WIDTH-1:0] p1_x,
    input  wire logic signed [COORD_WIDTH-1:0] p1_y,
    input  wire logic signed [COORD_WIDTH-1:0] p2_x,
    input  wire logic signed [COORD_WIDTH-1:0] p2_y,
    input  wire logic signed [COORD_WIDTH-1:0] p3_x,
    input  wire logic signed [COORD_WIDTH-1:0] p3_y,
    input  wire logic [cbpg_pkg::CNT_BITS-1:0] segment_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic [cbpg_pkg::CNT_BITS-1:0]      point_index,
    output logic                               last_point
);
    import cbpg_pkg::*;
    logic signed [COORD_WIDTH-1:0] cx_reg [4], cy_reg [4];
    logic                s_valid, s_last, en, p_valid, p_last, pipe_busy;
    logic [CNT_BITS-1:0] s_idx, s_n, p_idx;
    logic signed [COORD_WIDTH-1:0] p_x, p_y;
    logic                ov_reg;

    // Hold control points for the item in flight
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cx_reg[0] <= p0_x; cx_reg[1] <= p1_x; cx_reg[2] <= p2_x; cx_reg[3] <= p3_x;
            cy_reg[0] <= p0_y; cy_reg[1] <= p1_y; cy_reg[2] <= p2_y; cy_reg[3] <= p3_y;
        end
    end

    // Stall the whole pipe while a finished beat waits
    assign en = !(out_valid && !out_ready);

    cbpg_seq u_seq (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .n_in(segment_count), .hold(pipe_busy), .adv(en), .s_valid(s_valid),
        .s_idx(s_idx), .s_n(s_n), .s_last(s_last)
    );

    cbpg_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_pipe (
        .clk(clk), .rst_n(rst_n), .en(en), .i_valid(s_valid), .i_idx(s_idx),
        .i_n(s_n), .i_last(s_last), .cx(cx_reg), .cy(cy_reg),
        .o_valid(p_valid), .o_x(p_x), .o_y(p_y), .o_idx(p_idx), .o_last(p_last),
        .o_head_busy(pipe_busy)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= p_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_x     <= p_x;
            point_y     <= p_y;
            point_index <= p_idx;
            last_point  <= p_last;
        end
    end

    assign out_valid = ov_reg;

    a_first_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (s_idx == '0))
        else $error("sequencer did not restart at index zero");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid |-> !in_ready)
        else $error("item accepted while points remain");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(point_index) && out_valid)
        else $error("output changed under stall");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the cubic Bezier point generator.
`default_nettype none

// Predicted curve points and their in-order check against the block's beats.
class curve_scoreboard;
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [5:0]         index;
        logic               last;
    } curve_point_t;

    curve_point_t pending_points[$];
    int           error_count;
    int           points_checked;

    // Blend four coordinates with Q1.48 weights, round half up.
    static function logic [31:0] blend_axis(input logic signed [31:0] c0, c1, c2, c3,
                                            input logic [63:0] w0, w1, w2, w3);
        logic signed [127:0] acc;
        begin
            acc = $signed(128'(c0)) * $signed({64'd0, w0})
                + $signed(128'(c1)) * $signed({64'd0, w1})
                + $signed(128'(c2)) * $signed({64'd0, w2})
                + $signed(128'(c3)) * $signed({64'd0, w3})
                + (128'sd1 <<< 47);
            acc = acc >>> 48;
            return acc[31:0];
        end
    endfunction

    // Note an accepted item: expand it into its expected curve points.
    function void note_item(input logic signed [31:0] cx[4], cy[4], input logic [5:0] count);
        curve_point_t pt;
        logic [63:0]  t, u, w0, w1, w2, w3;
        int           n;
        begin
            n = count;
            if (n == 0)
            begin
                pt.x = cx[0];
                pt.y = cy[0];
                pt.index = 6'd0;
                pt.last = 1'b1;
                pending_points = {pending_points, pt};
                return;
            end
            for (int i = 0; i <= n; i++)
            begin
                t = ((64'(i) << 17) + 64'(n)) / (2 * 64'(n));
                u = 64'd65536 - t;
                w0 = u * u * u;
                w1 = 3 * u * u * t;
                w2 = 3 * u * t * t;
                w3 = t * t * t;
                pt.x = blend_axis(cx[0], cx[1], cx[2], cx[3], w0, w1, w2, w3);
                pt.y = blend_axis(cy[0], cy[1], cy[2], cy[3], w0, w1, w2, w3);
                pt.index = 6'(i);
                pt.last = (i == n);
                pending_points = {pending_points, pt};
            end
        end
    endfunction

    // Compare one output beat against the oldest expected point.
    function void check_point(input logic signed [31:0] x, y, input logic [5:0] idx,
                              input logic last);
        curve_point_t pt;
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected point beat x=%0d y=%0d index=%0d", x, y, idx);
                error_count++;
                return;
            end
            pt = pending_points.pop_front();
            points_checked++;
            if (x !== pt.x)
            begin
                $error("point_x expected %0d actual %0d", pt.x, x);
                error_count++;
            end
            if (y !== pt.y)
            begin
                $error("point_y expected %0d actual %0d", pt.y, y);
                error_count++;
            end
            if (idx !== pt.index)
            begin
                $error("point_index expected %0d actual %0d", pt.index, idx);
                error_count++;
            end
            if (last !== pt.last)
            begin
                $error("last_point expected %0b actual %0b", pt.last, last);
                error_count++;
            end
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 350;
    localparam int DRAIN_CYCLES   = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic [5:0]         segment_count;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] point_x, point_y;
    logic [5:0]         point_index;
    logic               last_point;

    curve_scoreboard    board;
    int                 items_sent;
    int                 idle_cycles;

    cubic_bezier_point_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
        .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
        .segment_count(segment_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x(point_x), .point_y(point_y),
        .point_index(point_index), .last_point(last_point)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        board = new();
        in_valid = 1'b0;
        out_ready = 1'b0;
        {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} = '0;
        segment_count = 6'd1;
    end

    // Check output beats and note input beats at each edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_point(point_x, point_y, point_index, last_point);
        if (rst_n && in_valid && in_ready)
            board.note_item('{p0_x, p1_x, p2_x, p3_x}, '{p0_y, p1_y, p2_y, p3_y},
                            segment_count);
    end

    // Stall the receiver on a cycling pattern: open stretches, then random stalls.
    always @(posedge clk)
    begin
        int phase;
        phase = ($time / 20) % 400;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (phase < 100)
            out_ready <= 1'b1;
        else if (phase < 250)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= ($urandom_range(0, 2) == 0);
    end

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random coordinate: mostly full range, sometimes extremes or small values.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until accepted.
    task automatic send_curve(input logic [31:0] c[8], input logic [5:0] count);
        @(posedge clk);
        in_valid <= 1'b1;
        {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} <=
            {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
        segment_count <= count;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
        items_sent++;
    endtask

    // Send one item with random content and a mostly small count.
    task automatic send_random_curve();
        logic [31:0] c[8];
        logic [5:0]  count;
        for (int k = 0; k < 8; k++) c[k] = pick_coord();
        case ($urandom_range(0, 9))
            0: count = 6'd63;
            1: count = 6'd0;
            2: count = 6'($urandom_range(1, 63));
            default: count = 6'($urandom_range(1, 8));
        endcase
        send_curve(c, count);
    endtask

    task automatic wait_for_drain();
        while (board.pending_points.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] c[8];
        int burst;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, both counts at the edges, zero count, flat curves.
        c = '{default: 32'h7fff_ffff};       send_curve(c, 6'd1);
        c = '{default: 32'h8000_0000};       send_curve(c, 6'd63);
        c = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
        send_curve(c, 6'd63);
        send_curve(c, 6'd0);
        c = '{default: 32'd0};               send_curve(c, 6'd2);
        c = '{32'h0001_0000, 32'hffff_0000, 32'h0003_0000, 32'h0002_0000,
              32'hfffd_0000, 32'h0004_8000, 32'h000a_0000, 32'hfff6_0000};
        for (int n = 1; n <= 6; n++) send_curve(c, 6'(n));
        send_curve(c, 6'd3);
        c = '{default: 32'hffff_ffff};       send_curve(c, 6'd7);
        c = '{32'd1, 32'hffff_ffff, 32'd0, 32'd1, 32'hffff_ffff, 32'd0, 32'd1, 32'd0};
        send_curve(c, 6'd5);
        send_curve(c, 6'd0);
        c = '{32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
              32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa};
        send_curve(c, 6'd32);
        send_curve(c, 6'd31);

        // Hold off until every expected point has left the block.
        wait_for_drain();

        // Random bursts with random gaps in between.
        while (items_sent < RANDOM_ITEMS + 20)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) send_random_curve();
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
            else if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 30)) @(posedge clk);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d curves, checked %0d points with random gaps and stalls.",
                 items_sent, board.points_checked);
        if (board.error_count == 0 && board.pending_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
